// File: hdl/tsss_pkg.sv
// Shared constants, codes and control types for the two-sided stack store.
`timescale 1ns / 1ps
`default_nettype none

package tsss_pkg;

   // Memory geometry: words shared by both stacks
   localparam int DEPTH    = 256;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = 9;
   localparam int SUM_W    = CNT_W + 1;
   localparam int DATA_W   = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   // Request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_PEEK  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // Controller states
   typedef enum logic {
      CTRL_IDLE,
      CTRL_ACCESS
   } ctrl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic start;  // request taken: decide, update fills, drive memory
      logic load;   // memory read data valid: capture response
   } dp_cmd_type;

endpackage

`default_nettype wire

// File: hdl/tsss_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tsss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write-or-read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/tsss_ctrl.sv
// Controller: request/response handshake and access sequencing.
`timescale 1ns / 1ps
`default_nettype none

module tsss_ctrl
   import tsss_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;
   logic           accept;

   // Response slot is free, or drains at this edge
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // State and response-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTRL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      accept    = 1'b0;
      req_stall = 1'b1;
      cmd       = '0;
      unique case (state_ff)
         CTRL_IDLE: begin
            req_stall = !slot_free;
            accept    = req_valid && slot_free;
            cmd.start = accept;
            if (accept) begin
               state_in = CTRL_ACCESS;
            end
         end
         CTRL_ACCESS: begin
            cmd.load = 1'b1;
            state_in = CTRL_IDLE;
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

   // Response valid: set on load, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: hdl/tsss_datapath.sv
// Datapath: fill counters, address generation, shared memory and response register.
`timescale 1ns / 1ps
`default_nettype none

module tsss_datapath
   import tsss_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire dp_cmd_type               cmd,
   input  wire logic [OP_W-1:0]          req_op,
   input  wire logic                     req_side,
   input  wire logic signed [DATA_W-1:0] req_push_value,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic signed [DATA_W-1:0]      rsp_read_value,
   output logic [CNT_W-1:0]              rsp_left_count,
   output logic [CNT_W-1:0]              rsp_right_count
);

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

   logic [CNT_W-1:0]    left_fill_ff, left_fill_in;
   logic [CNT_W-1:0]    right_fill_ff, right_fill_in;
   status_type          status_ff, status_in;
   logic                rd_en_ff, rd_en_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [DATA_W-1:0]   rsp_read_value_ff;
   logic [CNT_W-1:0]    rsp_left_count_ff;
   logic [CNT_W-1:0]    rsp_right_count_ff;

   op_type            op;
   logic              full;
   logic [CNT_W-1:0]  sel_fill;
   logic [CNT_W-1:0]  right_top;
   logic              wr_en;
   logic [ADDR_W-1:0] addr;
   logic [DATA_W-1:0] rd_data;

   assign op       = op_type'(req_op);
   assign full     = ({1'b0, left_fill_ff} + {1'b0, right_fill_ff}) >= DEPTH_S;
   assign sel_fill = req_side ? right_fill_ff : left_fill_ff;
   // Right top word sits at DEPTH - right_fill
   assign right_top = DEPTH_C - right_fill_ff;

   // Operation decode: fills, status, memory access
   always_comb begin
      left_fill_in  = left_fill_ff;
      right_fill_in = right_fill_ff;
      status_in     = status_ff;
      rd_en_in      = rd_en_ff;
      wr_en         = 1'b0;
      addr          = '0;
      if (cmd.start) begin
         status_in = STAT_OK;
         rd_en_in  = 1'b0;
         unique case (op)
            OP_PUSH: begin
               if (full) begin
                  status_in = STAT_FULL;
               end else if (!req_side) begin
                  wr_en        = 1'b1;
                  addr         = left_fill_ff[ADDR_W-1:0];
                  left_fill_in = left_fill_ff + 1'b1;
               end else begin
                  wr_en         = 1'b1;
                  addr          = ADDR_W'(DEPTH - 1) - right_fill_ff[ADDR_W-1:0];
                  right_fill_in = right_fill_ff + 1'b1;
               end
            end
            OP_POP, OP_PEEK: begin
               if (sel_fill == '0) begin
                  status_in = STAT_EMPTY;
               end else begin
                  rd_en_in = 1'b1;
                  if (!req_side) begin
                     addr = ADDR_W'(left_fill_ff - 1'b1);
                     if (op == OP_POP) begin
                        left_fill_in = left_fill_ff - 1'b1;
                     end
                  end else begin
                     addr = right_top[ADDR_W-1:0];
                     if (op == OP_POP) begin
                        right_fill_in = right_fill_ff - 1'b1;
                     end
                  end
               end
            end
            OP_CLEAR: begin
               if (!req_side) begin
                  left_fill_in = '0;
               end else begin
                  right_fill_in = '0;
               end
            end
            default: begin
               status_in = STAT_OK;
            end
         endcase
      end
   end

   // Fill counters
   always_ff @(posedge clock) begin
      if (reset) begin
         left_fill_ff  <= '0;
         right_fill_ff <= '0;
      end else begin
         left_fill_ff  <= left_fill_in;
         right_fill_ff <= right_fill_in;
      end
   end

   // Decision held across the memory read
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rd_en_ff  <= rd_en_in;
   end

   tsss_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (addr),
      .wr_data (req_push_value),
      .rd_data (rd_data)
   );

   // Response register, held until taken
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_status_ff      <= status_ff;
         rsp_read_value_ff  <= rd_en_ff ? rd_data : '0;
         rsp_left_count_ff  <= left_fill_ff;
         rsp_right_count_ff <= right_fill_ff;
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_left_count  = rsp_left_count_ff;
   assign rsp_right_count = rsp_right_count_ff;

endmodule

`default_nettype wire

// File: hdl/two_sided_stack_store.sv
// Top level of the two-sided stack store.
`timescale 1ns / 1ps
`default_nettype none

// Two LIFO stacks in one 256-word memory: the left stack grows up from word 0,
// the right stack grows down from the top word. Each request pushes, pops, peeks
// or clears one side and returns one response with a status, the word read (zero
// unless a pop or peek succeeds) and both fill counts after the operation. A
// request first accesses the single-port memory, then its registered read data
// reaches the response register; no new request is taken until that is done.
// The response register holds a result while the receiver stalls, and the next
// request is taken in the cycle the held response leaves. Reset empties both
// stacks; no clearing pass is needed.
module two_sided_stack_store
   import tsss_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [OP_W-1:0]          req_op,
   input  wire logic                     req_side,
   input  wire logic signed [DATA_W-1:0] req_push_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic signed [DATA_W-1:0]      rsp_read_value,
   output logic [CNT_W-1:0]              rsp_left_count,
   output logic [CNT_W-1:0]              rsp_right_count
);

   dp_cmd_type cmd;

   tsss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   tsss_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (req_op),
      .req_side        (req_side),
      .req_push_value  (req_push_value),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_left_count  (rsp_left_count),
      .rsp_right_count (rsp_right_count)
   );

`ifndef NO_ASSERTIONS
   // An accepted request shows its response once the access state has loaded it
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 rsp_valid)
      else $error("response missing after accepted request");

   // No request taken while a held response is stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request accepted over a stalled response");

   // Stacks never overlap
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_left_count} + {1'b0, rsp_right_count}) <= SUM_W'(DEPTH))
      else $error("stack fills exceed memory depth");

   // Failed operations read nothing
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |-> rsp_read_value == '0)
      else $error("nonzero read value on error response");
`endif

endmodule

`default_nettype wire

// File: bench/two_sided_stack_store_checker.sv
// Checker for the two-sided stack store: predicts every response and compares it.
`timescale 1ns / 1ps

module two_sided_stack_store_checker
   import tsss_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [OP_W-1:0]          req_op,
   input  logic                     req_side,
   input  logic signed [DATA_W-1:0] req_push_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [STATUS_W-1:0]      rsp_status,
   input  logic signed [DATA_W-1:0] rsp_read_value,
   input  logic [CNT_W-1:0]         rsp_left_count,
   input  logic [CNT_W-1:0]         rsp_right_count,
   output int                       fail_count,
   output int                       pending_results
);

   // One expected response
   typedef struct packed {
      status_type          status;
      logic [DATA_W-1:0]   read_value;
      logic [CNT_W-1:0]    left_count;
      logic [CNT_W-1:0]    right_count;
   } stack_result_type;

   // Shadow copy of the shared memory and both fill counts
   logic [DATA_W-1:0] stack_words [DEPTH];
   int                left_fill;
   int                right_fill;
   stack_result_type  expected_responses [$];

   // Apply one request to the shadow stacks and return its response
   function automatic stack_result_type apply_request(op_type op, logic side,
                                                      logic [DATA_W-1:0] word);
      stack_result_type r;
      int               fill;
      r.status     = STAT_OK;
      r.read_value = '0;
      case (op)
         OP_PUSH: begin
            if (left_fill + right_fill >= DEPTH) begin
               r.status = STAT_FULL;
            end else if (!side) begin
               stack_words[left_fill] = word;
               left_fill++;
            end else begin
               stack_words[DEPTH - 1 - right_fill] = word;
               right_fill++;
            end
         end
         OP_POP, OP_PEEK: begin
            fill = side ? right_fill : left_fill;
            if (fill == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               // left top sits just below its fill, right top at DEPTH - fill
               r.read_value = side ? stack_words[DEPTH - right_fill]
                                   : stack_words[left_fill - 1];
               if (op == OP_POP) begin
                  if (side) right_fill--;
                  else      left_fill--;
               end
            end
         end
         default: begin
            // clear drops the count only; words stay in memory
            if (side) right_fill = 0;
            else      left_fill = 0;
         end
      endcase
      r.left_count  = CNT_W'(left_fill);
      r.right_count = CNT_W'(right_fill);
      return r;
   endfunction

   // Request side first, then response side, so ordering holds in one edge
   always @(posedge clock) begin
      stack_result_type want;
      if (reset) begin
         left_fill  = 0;
         right_fill = 0;
         fail_count = 0;
         expected_responses.delete();
      end else begin
         if (req_valid && !req_stall)
            expected_responses.push_back(apply_request(op_type'(req_op), req_side,
                                                       req_push_value));
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_read_value !== want.read_value) begin
                  $error("rsp_read_value: expected %h, got %h",
                         want.read_value, rsp_read_value);
                  fail_count++;
               end
               if (rsp_left_count !== want.left_count) begin
                  $error("rsp_left_count: expected %0d, got %0d",
                         want.left_count, rsp_left_count);
                  fail_count++;
               end
               if (rsp_right_count !== want.right_count) begin
                  $error("rsp_right_count: expected %0d, got %0d",
                         want.right_count, rsp_right_count);
                  fail_count++;
               end
            end
         end
      end
      pending_results = expected_responses.size();
   end

endmodule

// File: bench/tb_two_sided_stack_store.sv
// Testbench top for the two-sided stack store: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_two_sided_stack_store;
   import tsss_pkg::*;

   localparam int ITEM_TARGET = 450;
   localparam int CYCLE_LIMIT = 200000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [OP_W-1:0]          req_op;
   logic                     req_side;
   logic signed [DATA_W-1:0] req_push_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [CNT_W-1:0]         rsp_left_count;
   logic [CNT_W-1:0]         rsp_right_count;
   int                       fail_count;
   int                       pending_results;

   // Stimulus bookkeeping
   int sent_count  = 0;
   int left_n      = 0;
   int right_n     = 0;
   int cycle_count = 0;
   int stall_left  = 0;
   bit quiet_spell = 1'b0;
   bit rsp_taken   = 1'b0;

   two_sided_stack_store dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_side        (req_side),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_left_count  (rsp_left_count),
      .rsp_right_count (rsp_right_count)
   );

   two_sided_stack_store_checker stack_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_side        (req_side),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_left_count  (rsp_left_count),
      .rsp_right_count (rsp_right_count),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: note each taken response at the rising edge
   always @(posedge clock) begin
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
   end

   // After each taken response, maybe stall the receiver (never in a quiet spell)
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_taken)
            stall_left = quiet_spell ? 0 : $urandom_range(0, 3);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Present one request after a random gap; returns at the next falling edge
   task automatic send_request(input op_type op, input logic side,
                               input logic [DATA_W-1:0] word);
      int gap;
      gap = quiet_spell ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_side       <= side;
      req_push_value <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent_count++;
      // rough occupancy, used only to steer the random mix
      case (op)
         OP_PUSH:
            if (left_n + right_n < DEPTH) begin
               if (side) right_n++;
               else      left_n++;
            end
         OP_POP: begin
            if (side && right_n > 0)  right_n--;
            if (!side && left_n > 0)  left_n--;
         end
         OP_CLEAR: begin
            if (side) right_n = 0;
            else      left_n = 0;
         end
         default: ;
      endcase
   endtask

   // Hold off until every outstanding response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   function automatic logic [DATA_W-1:0] random_word();
      logic [DATA_W-1:0] corners [4];
      corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
      if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 3)];
      return $urandom;
   endfunction

   initial begin
      int bias;
      int burst_len;
      int push_lim;
      int pop_lim;
      int peek_lim;
      int pick;
      op_type op;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = OP_PUSH;
      req_side       = 1'b0;
      req_push_value = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty reads, corner words on both sides, peek/pop, clear
      send_request(OP_POP,   1'b0, 32'h0);
      send_request(OP_PEEK,  1'b1, 32'h0);
      send_request(OP_PUSH,  1'b0, 32'h7FFF_FFFF);
      send_request(OP_PUSH,  1'b0, 32'h8000_0000);
      send_request(OP_PUSH,  1'b1, 32'h0000_0000);
      send_request(OP_PUSH,  1'b1, 32'hFFFF_FFFF);
      send_request(OP_PEEK,  1'b0, 32'h0);
      send_request(OP_PEEK,  1'b1, 32'h0);
      send_request(OP_POP,   1'b0, 32'h0);
      send_request(OP_POP,   1'b1, 32'h0);
      send_request(OP_POP,   1'b0, 32'h0);
      send_request(OP_POP,   1'b0, 32'h0);
      send_request(OP_POP,   1'b1, 32'h0);
      send_request(OP_POP,   1'b1, 32'h0);
      send_request(OP_PUSH,  1'b0, 32'hA5A5_A5A5);
      send_request(OP_PUSH,  1'b1, 32'h5A5A_5A5A);
      send_request(OP_CLEAR, 1'b0, 32'h0);
      send_request(OP_PEEK,  1'b0, 32'h0);
      send_request(OP_PEEK,  1'b1, 32'h0);
      send_request(OP_CLEAR, 1'b1, 32'h0);
      send_request(OP_CLEAR, 1'b1, 32'h0);
      send_request(OP_CLEAR, 1'b0, 32'h0);

      // Sender stops until all results are in
      wait_drained();

      // Fill the memory from both ends, then push into a full store
      while (left_n + right_n < DEPTH)
         send_request(OP_PUSH, 1'($urandom_range(0, 1)), random_word());
      send_request(OP_PUSH, 1'b0, random_word());
      send_request(OP_PUSH, 1'b1, random_word());
      send_request(OP_PEEK, 1'b0, 32'h0);
      send_request(OP_PEEK, 1'b1, 32'h0);
      send_request(OP_POP,  1'b1, 32'h0);
      send_request(OP_PUSH, 1'b0, random_word());
      send_request(OP_PUSH, 1'b1, random_word());

      // Random bursts: growing, shrinking or mixed, some with no idling
      while (sent_count < ITEM_TARGET) begin
         bias        = $urandom_range(0, 2);
         burst_len   = $urandom_range(8, 24);
         quiet_spell = ($urandom_range(0, 3) == 0);
         case (bias)
            0:       begin push_lim = 60; pop_lim = 78; peek_lim = 98; end
            1:       begin push_lim = 20; pop_lim = 70; peek_lim = 98; end
            default: begin push_lim = 40; pop_lim = 70; peek_lim = 97; end
         endcase
         repeat (burst_len) begin
            pick = $urandom_range(0, 99);
            if (pick < push_lim)      op = OP_PUSH;
            else if (pick < pop_lim)  op = OP_POP;
            else if (pick < peek_lim) op = OP_PEEK;
            else                      op = OP_CLEAR;
            send_request(op, 1'($urandom_range(0, 1)), random_word());
         end
      end
      quiet_spell = 1'b0;

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
